// File: design/svf_pkg.sv
// Shared types, constants and the character check for the short-name validator.
`timescale 1ns / 1ps

package svf_pkg;

    localparam logic [7:0] SPACE_CODE  = 8'h20;
    localparam logic [7:0] DOT_CODE    = 8'h2E;
    localparam logic [7:0] LOWER_A     = 8'h61;
    localparam logic [7:0] LOWER_Z     = 8'h7A;
    localparam logic [7:0] UPPER_A     = 8'h41;
    localparam logic [7:0] UPPER_Z     = 8'h5A;
    localparam logic [7:0] DIGIT_0     = 8'h30;
    localparam logic [7:0] DIGIT_9     = 8'h39;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef struct packed {
        logic load;
        logic ok;
    } t_burst_ctl;

    function automatic logic char_allowed(input logic [7:0] c);
        logic ok;
        ok = 1'b0;
        if (c >= UPPER_A && c <= UPPER_Z) begin
            ok = 1'b1;
        end
        if (c >= DIGIT_0 && c <= DIGIT_9) begin
            ok = 1'b1;
        end
        // ! # $ % & ' ( ) - @ ^ _ ` { } ~
        case (c) inside
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29,
            8'h2D, 8'h40, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7D, 8'h7E: begin
                ok = 1'b1;
            end
            default: begin
            end
        endcase
        return ok;
    endfunction

endpackage

// File: design/svf_accum.sv
// Input register and name accumulator: case folding, checks, counts and entry store.
`timescale 1ns / 1ps

module svf_accum #(
    parameter int BASE_LEN  = 8,
    parameter int EXT_LEN   = 3,
    parameter int ENTRY_LEN = BASE_LEN + EXT_LEN,
    parameter int IDX_W     = $clog2(ENTRY_LEN)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_char,
    input  logic                        i_last,
    input  logic                        i_folder,
    input  logic                        i_can_load,
    output svf_pkg::t_burst_ctl         o_ctl,
    output logic [ENTRY_LEN-1:0][7:0]   o_entry
);
    import svf_pkg::*;

    localparam int BCNT_W = $clog2(BASE_LEN + 2);
    localparam int ECNT_W = $clog2(EXT_LEN + 2);

    logic                       r_vld;
    logic [7:0]                 r_char;
    logic                       r_last;
    logic                       r_folder;

    logic [ENTRY_LEN-1:0][7:0]  r_store, n_store;
    logic [BCNT_W-1:0]          r_base, n_base;
    logic [ECNT_W-1:0]          r_ext, n_ext;
    logic                       r_dot, n_dot;
    logic                       r_sv, n_sv;
    logic                       r_mode;
    logic                       r_in_name;

    logic                       advance;
    logic                       mode;
    logic [7:0]                 c;
    logic [IDX_W-1:0]           widx;
    logic                       ok_w;

    assign advance = r_vld && (!r_last || i_can_load);
    assign o_ready = !r_vld || advance;
    assign mode    = r_in_name ? r_mode : r_folder;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char   <= i_char;
            r_last   <= i_last;
            r_folder <= i_folder;
        end
    end

    always_comb begin
        c = r_char;
        if (r_char >= LOWER_A && r_char <= LOWER_Z) begin
            c = r_char - CASE_OFFSET;
        end
        n_store = r_store;
        n_base  = r_base;
        n_ext   = r_ext;
        n_dot   = r_dot;
        n_sv    = r_sv;
        widx    = IDX_W'(r_base);
        if (c == DOT_CODE && !r_dot) begin
            n_dot = 1'b1;
            if (mode) begin
                n_sv = 1'b0;
            end
        end else begin
            if (!char_allowed(c)) begin
                n_sv = 1'b0;
            end
            if (!r_dot) begin
                widx = IDX_W'(r_base);
                if (r_base < BCNT_W'(BASE_LEN)) begin
                    n_store[widx] = c;
                end
                if (r_base <= BCNT_W'(BASE_LEN)) begin
                    n_base = r_base + BCNT_W'(1);
                end
            end else begin
                widx = IDX_W'(BASE_LEN) + IDX_W'(r_ext);
                if (r_ext < ECNT_W'(EXT_LEN)) begin
                    n_store[widx] = c;
                end
                if (r_ext <= ECNT_W'(EXT_LEN)) begin
                    n_ext = r_ext + ECNT_W'(1);
                end
            end
        end
        ok_w = n_sv && (mode || (n_base != '0 && n_base <= BCNT_W'(BASE_LEN)
                                 && n_ext <= ECNT_W'(EXT_LEN)));
    end

    assign o_ctl.load = advance && r_last;
    assign o_ctl.ok   = ok_w;
    assign o_entry    = n_store;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store   <= {ENTRY_LEN{SPACE_CODE}};
            r_base    <= '0;
            r_ext     <= '0;
            r_dot     <= 1'b0;
            r_sv      <= 1'b1;
            r_mode    <= 1'b0;
            r_in_name <= 1'b0;
        end else if (advance) begin
            if (r_last) begin
                r_store   <= {ENTRY_LEN{SPACE_CODE}};
                r_base    <= '0;
                r_ext     <= '0;
                r_dot     <= 1'b0;
                r_sv      <= 1'b1;
                r_mode    <= 1'b0;
                r_in_name <= 1'b0;
            end else begin
                r_store   <= n_store;
                r_base    <= n_base;
                r_ext     <= n_ext;
                r_dot     <= n_dot;
                r_sv      <= n_sv;
                r_mode    <= mode;
                r_in_name <= 1'b1;
            end
        end
    end

    a_stall_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_vld && r_last && !i_can_load))
        else $error("input stalled without a pending last item");

    a_base_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base <= BCNT_W'(BASE_LEN + 1) && r_ext <= ECNT_W'(EXT_LEN + 1))
        else $error("name counts ran past saturation");

    a_clear_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> (r_base == '0 && r_ext == '0 && !r_dot && r_sv && !r_in_name))
        else $error("name state not cleared after burst load");

endmodule

// File: design/svf_burst.sv
// Entry snapshot and 11-item output burst sequencer.
`timescale 1ns / 1ps

module svf_burst #(
    parameter int ENTRY_LEN = 11,
    parameter int IDX_W     = $clog2(ENTRY_LEN)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  svf_pkg::t_burst_ctl         i_ctl,
    input  logic [ENTRY_LEN-1:0][7:0]   i_entry,
    output logic                        o_can_load,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [7:0]                  o_byte,
    output logic [IDX_W-1:0]            o_index,
    output logic                        o_ok,
    output logic                        o_last
);
    import svf_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_LEN - 1);

    logic [ENTRY_LEN-1:0][7:0]  r_buf;
    logic                       r_ok;
    logic                       r_busy;
    logic [IDX_W-1:0]           r_idx;
    logic                       finishing;

    assign finishing  = r_busy && i_ready && (r_idx == LAST_IDX);
    assign o_can_load = !r_busy || finishing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_ctl.load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && i_ready) begin
            if (r_idx == LAST_IDX) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_buf <= i_entry;
            r_ok  <= i_ctl.ok;
        end
    end

    assign o_valid = r_busy;
    assign o_byte  = r_buf[r_idx];
    assign o_index = r_idx;
    assign o_ok    = r_ok;
    assign o_last  = (r_idx == LAST_IDX);

    a_start_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> (r_idx == '0))
        else $error("burst did not start at index zero");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load |-> o_can_load)
        else $error("entry loaded over a burst in progress");

    a_idle_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finishing && !i_ctl.load) |=> !r_busy)
        else $error("burst kept running past its last item");

endmodule

// File: design/short_name_validate_format_unit.sv
// Top level: 8.3 short-name checker with stream input and output.
// Timing: a character item is registered, then folded into the name state from
// that register; a last item loads the entry into the burst buffer, which then
// sends one result item a cycle while the receiver is ready (ENTRY_LEN in all).
// Throughput: one character item per cycle; a last item stalls only until the
// burst of the previous name hands off its final item.
// Reset: synchronous, active low; entry store returns to spaces, counts clear.
`timescale 1ns / 1ps

module short_name_validate_format_unit #(
    parameter int BASE_LEN = 8,
    parameter int EXT_LEN  = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] char_code
    input  logic                        s_axis_tlast,
    input  logic                        s_axis_tuser,   // [0] folder_mode
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [7:0] entry_byte, then byte_index; zero pad above
    output logic [((8 + $clog2(BASE_LEN + EXT_LEN) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic                        m_axis_tlast,
    output logic                        m_axis_tuser    // [0] name_valid
);
    import svf_pkg::*;

    localparam int ENTRY_LEN = BASE_LEN + EXT_LEN;
    localparam int IDX_W     = $clog2(ENTRY_LEN);
    localparam int TDATA_W   = ((8 + IDX_W + 7) / 8) * 8;

    t_burst_ctl                 ctl;
    logic [ENTRY_LEN-1:0][7:0]  entry;
    logic                       can_load;
    logic [7:0]                 out_byte;
    logic [IDX_W-1:0]           out_index;

    svf_accum #(
        .BASE_LEN  (BASE_LEN),
        .EXT_LEN   (EXT_LEN),
        .ENTRY_LEN (ENTRY_LEN),
        .IDX_W     (IDX_W)
    ) u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_char     (s_axis_tdata),
        .i_last     (s_axis_tlast),
        .i_folder   (s_axis_tuser),
        .i_can_load (can_load),
        .o_ctl      (ctl),
        .o_entry    (entry)
    );

    svf_burst #(
        .ENTRY_LEN (ENTRY_LEN),
        .IDX_W     (IDX_W)
    ) u_burst (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_entry    (entry),
        .o_can_load (can_load),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_byte     (out_byte),
        .o_index    (out_index),
        .o_ok       (m_axis_tuser),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = TDATA_W'({out_index, out_byte});

endmodule

// File: test/svf_checker.sv
// Checker for the short-name validator: predicts each name's entry and compares result items.
`timescale 1ns / 1ps

module svf_checker #(
    parameter int BASE_LEN = 8,
    parameter int EXT_LEN  = 3,
    parameter int OUT_W    = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [7:0]       i_in_char,
    input  logic             i_in_last,
    input  logic             i_in_folder,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [OUT_W-1:0] i_out_data,     // [7:0] entry_byte, [11:8] byte_index
    input  logic             i_out_last,
    input  logic             i_out_name_ok,
    output int               o_pending,
    output int               o_fail_count,
    output int               o_checked
);
    import svf_pkg::*;

    localparam int ENTRY_LEN = BASE_LEN + EXT_LEN;

    typedef struct packed {
        logic [7:0] entry_byte;
        logic [3:0] byte_index;
        logic       name_valid;
        logic       last_byte;
    } t_entry_item;

    t_entry_item entry_bytes_due[$];

    logic [7:0] entry_img [ENTRY_LEN];
    int         base_cnt;
    int         ext_cnt;
    logic       dot_taken;
    logic       chars_ok;
    logic       folder_name;
    logic       name_open;
    int         fails;
    int         checked;

    function automatic logic is_short_name_char(logic [7:0] c);
        string punct = "!#$%&'()-@^_`{}~";
        if (c >= UPPER_A && c <= UPPER_Z) begin
            return 1'b1;
        end
        if (c >= DIGIT_0 && c <= DIGIT_9) begin
            return 1'b1;
        end
        for (int i = 0; i < punct.len(); i++) begin
            if (punct[i] == c) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void clear_name();
        for (int i = 0; i < ENTRY_LEN; i++) begin
            entry_img[i] = SPACE_CODE;
        end
        base_cnt    = 0;
        ext_cnt     = 0;
        dot_taken   = 1'b0;
        chars_ok    = 1'b1;
        folder_name = 1'b0;
        name_open   = 1'b0;
    endfunction

    // Folds one character into the name; on the last one queues the whole entry.
    function automatic void fold_name_char(logic [7:0] c_in, logic last, logic folder);
        logic [7:0]  c;
        logic        ok;
        t_entry_item e;
        c = c_in;
        if (!name_open) begin
            folder_name = folder;
            name_open   = 1'b1;
        end
        if (c >= LOWER_A && c <= LOWER_Z) begin
            c = c - CASE_OFFSET;
        end
        if (c == DOT_CODE && !dot_taken) begin
            dot_taken = 1'b1;
            if (folder_name) begin
                chars_ok = 1'b0;
            end
        end else begin
            if (!is_short_name_char(c)) begin
                chars_ok = 1'b0;
            end
            if (!dot_taken) begin
                if (base_cnt < BASE_LEN) begin
                    entry_img[base_cnt] = c;
                end
                if (base_cnt <= BASE_LEN) begin
                    base_cnt++;
                end
            end else begin
                if (ext_cnt < EXT_LEN) begin
                    entry_img[BASE_LEN + ext_cnt] = c;
                end
                if (ext_cnt <= EXT_LEN) begin
                    ext_cnt++;
                end
            end
        end
        if (last) begin
            ok = chars_ok;
            if (!folder_name && (base_cnt == 0 || base_cnt > BASE_LEN || ext_cnt > EXT_LEN)) begin
                ok = 1'b0;
            end
            for (int i = 0; i < ENTRY_LEN; i++) begin
                e.entry_byte = entry_img[i];
                e.byte_index = 4'(i);
                e.name_valid = ok;
                e.last_byte  = (i == ENTRY_LEN - 1);
                entry_bytes_due.push_back(e);
            end
            clear_name();
        end
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fails++;
        end
    endtask

    initial begin
        clear_name();
        fails   = 0;
        checked = 0;
    end

    always @(posedge i_clk) begin
        t_entry_item e;
        if (!i_rst_n) begin
            entry_bytes_due.delete();
            clear_name();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (entry_bytes_due.size() == 0) begin
                    $error("result item with no expected entry byte (data 0x%0h)", i_out_data);
                    fails++;
                end else begin
                    e = entry_bytes_due.pop_front();
                    check_field("entry_byte", e.entry_byte, i_out_data[7:0]);
                    check_field("byte_index", e.byte_index, i_out_data[11:8]);
                    check_field("name_valid", e.name_valid, i_out_name_ok);
                    check_field("last_byte", e.last_byte, i_out_last);
                    checked++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                fold_name_char(i_in_char, i_in_last, i_in_folder);
            end
        end
        o_pending    <= entry_bytes_due.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

// File: test/tb.sv
// Testbench top: drives names into the short-name validator and gives the verdict.
`timescale 1ns / 1ps

module tb;
    import svf_pkg::*;

    localparam int BASE_LEN    = 8;
    localparam int EXT_LEN     = 3;
    localparam int OUT_W       = ((8 + $clog2(BASE_LEN + EXT_LEN) + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 20;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata = '0;    // [7:0] char_code
    logic             s_axis_tlast = 1'b0;
    logic             s_axis_tuser = 1'b0;  // [0] folder_mode
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;         // [7:0] entry_byte, [11:8] byte_index
    logic             m_axis_tlast;
    logic             m_axis_tuser;         // [0] name_valid

    int   pending;
    int   fail_count;
    int   checked;
    int   cycles = 0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    int   chars_sent = 0;
    int   names_sent = 0;
    logic hold_off = 1'b0;
    event hold_kick;

    always #5 i_clk = ~i_clk;

    short_name_validate_format_unit #(
        .BASE_LEN(BASE_LEN),
        .EXT_LEN (EXT_LEN)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    svf_checker #(
        .BASE_LEN(BASE_LEN),
        .EXT_LEN (EXT_LEN),
        .OUT_W   (OUT_W)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_char    (s_axis_tdata),
        .i_in_last    (s_axis_tlast),
        .i_in_folder  (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .i_out_name_ok(m_axis_tuser),
        .o_pending    (pending),
        .o_fail_count (fail_count),
        .o_checked    (checked)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
    end

    // long receiver hold-off, counted here so the sender keeps pushing meanwhile
    initial begin
        @(hold_kick);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d result items outstanding", cycles, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_char(logic [7:0] c, logic last, logic folder);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        s_axis_tuser  <= folder;
        do @(posedge i_clk); while (!s_axis_tready);
        chars_sent++;
    endtask

    // folder_mode only counts on the first item; later items carry noise there
    task automatic send_name(logic [7:0] chars[$], logic folder);
        for (int i = 0; i < chars.size(); i++) begin
            send_char(chars[i], i == chars.size() - 1, (i == 0) ? folder : 1'($urandom));
        end
        names_sent++;
    endtask

    task automatic send_text(string s, logic folder);
        logic [7:0] chars[$];
        for (int i = 0; i < s.len(); i++) begin
            chars.push_back(s[i]);
        end
        send_name(chars, folder);
    endtask

    function automatic logic [7:0] pick_legal();
        string punct = "!#$%&'()-@^_`{}~";
        case ($urandom_range(0, 3))
            0: return UPPER_A + 8'($urandom_range(0, 25));
            1: return LOWER_A + 8'($urandom_range(0, 25));
            2: return DIGIT_0 + 8'($urandom_range(0, 9));
            default: return punct[$urandom_range(0, punct.len() - 1)];
        endcase
    endfunction

    function automatic logic [7:0] pick_noisy();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8) begin
            return pick_legal();
        end else if (r == 8) begin
            return DOT_CODE;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random_name();
        logic [7:0] chars[$];
        logic       folder;
        int         kind;
        int         n;
        kind   = $urandom_range(0, 9);
        folder = 1'b0;
        if (kind <= 5) begin
            n = $urandom_range(1, BASE_LEN);
            repeat (n) chars.push_back(pick_legal());
            if ($urandom_range(0, 1)) begin
                chars.push_back(DOT_CODE);
                n = $urandom_range(0, EXT_LEN);
                repeat (n) chars.push_back(pick_legal());
            end
        end else if (kind == 6) begin
            folder = 1'b1;
            n = $urandom_range(1, 12);
            repeat (n) chars.push_back(pick_legal());
            if ($urandom_range(0, 3) == 0) begin
                chars.insert($urandom_range(0, chars.size()), DOT_CODE);
            end
        end else begin
            folder = 1'($urandom);
            n = $urandom_range(0, 11);
            repeat (n) chars.push_back(pick_noisy());
            if ($urandom_range(0, 1)) begin
                chars.push_back(DOT_CODE);
                n = $urandom_range(0, 5);
                repeat (n) chars.push_back(pick_noisy());
            end
            if (chars.size() == 0) begin
                chars.push_back(pick_noisy());
            end
        end
        send_name(chars, folder);
    endtask

    task automatic run_phase(int idle_pct, int stall, int n_items);
        int start;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        start         = chars_sent;
        while (chars_sent - start < n_items) begin
            send_random_name();
        end
    endtask

    initial begin
        logic [7:0] extremes[$];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed names
        send_text("a", 1'b0);             // one-item name, lower case
        extremes = '{8'h00, 8'hFF};
        send_name(extremes, 1'b0);        // zero byte and top byte
        send_text(".e", 1'b0);            // leading dot, empty base
        send_text("~.", 1'b0);            // trailing dot, empty extension
        send_text("g.h", 1'b1);           // dot in folder mode
        send_text("X.Y.Z", 1'b0);         // further dot
        send_text("ABCDEFGHI", 1'b0);     // base too long

        run_phase(0, 0, 90);
        run_phase(81, 0, 90);
        run_phase(0, 81, 90);
        run_phase(9, 9, 90);
        -> hold_kick;
        run_phase(0, 0, 40);

        s_axis_tvalid <= 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d names (%0d character items) across five traffic phases,", names_sent,
                 chars_sent);
        $display("including a long output hold-off; %0d result items compared.", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/svf_pkg.sv
design/svf_accum.sv
design/svf_burst.sv
design/short_name_validate_format_unit.sv
test/svf_checker.sv
test/tb.sv
